>>> hw/rtl/u2d_pkg.sv
package u2d_pkg;

	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned CHAR_W      = 6;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

	localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
	localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

endpackage

>>> hw/rtl/u2d_queue.sv
module u2d_queue #(
	parameter int unsigned DATA_W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [DATA_W-1:0]   wdata,
	input  logic                pop,
	output logic [DATA_W-1:0]   rdata,
	output u2d_pkg::queue_stat_t stat
);

	localparam int unsigned PTR_W = $clog2(u2d_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(u2d_pkg::QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] mem_q [u2d_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(u2d_pkg::QUEUE_DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(u2d_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(u2d_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/u2d_back.sv
module u2d_back #(
	parameter int unsigned DATA_W = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  u2d_pkg::queue_stat_t           qstat,
	input  logic [DATA_W-1:0]              qdata,
	output logic                           qpop,
	output logic                           valid,
	input  logic                           stall,
	output logic [u2d_pkg::CHAR_W-1:0]     digit_char,
	output logic                           last_digit
);

	localparam int unsigned NDIG  = (DATA_W * 30103) / 100000 + 1;
	localparam int unsigned BCD_W = u2d_pkg::DIGIT_W * NDIG;
	localparam int unsigned CMAX  = (DATA_W > NDIG) ? DATA_W : NDIG;
	localparam int unsigned CNT_W = $clog2(CMAX + 1);

	u2d_pkg::back_state_t state_q, state_d;

	logic [DATA_W-1:0]           bin_q;
	logic [BCD_W-1:0]            bcd_q;
	logic [BCD_W-1:0]            bcd_adj;
	logic [CNT_W-1:0]            cnt_q;
	logic                        started_q;
	logic                        valid_q;
	logic [u2d_pkg::CHAR_W-1:0]  char_q;
	logic                        last_q;

	logic [u2d_pkg::DIGIT_W-1:0] top_nib;
	logic                        out_free;
	logic                        last_dig;
	logic                        show;
	logic                        load;
	logic                        shift_en;
	logic                        emit_adv;
	logic                        emit_out;

	// add-3 correction on every digit before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			bcd_adj[i*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] =
				(bcd_q[i*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] >= u2d_pkg::ADJ_LIMIT)
				? bcd_q[i*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] + u2d_pkg::ADJ_ADD
				: bcd_q[i*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W];
		end
	end

	assign top_nib  = bcd_q[BCD_W-1 -: u2d_pkg::DIGIT_W];
	assign out_free = !valid_q || !stall;
	assign last_dig = (cnt_q == CNT_W'(1));
	assign show     = started_q || (top_nib != '0) || last_dig;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			u2d_pkg::ST_IDLE: begin
				if (!qstat.empty) state_d = u2d_pkg::ST_SHIFT;
			end
			u2d_pkg::ST_SHIFT: begin
				if (last_dig) state_d = u2d_pkg::ST_EMIT;
			end
			u2d_pkg::ST_EMIT: begin
				if (emit_adv && last_dig) state_d = u2d_pkg::ST_IDLE;
			end
			default: state_d = u2d_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		load     = 1'b0;
		shift_en = 1'b0;
		emit_adv = 1'b0;
		emit_out = 1'b0;
		unique case (state_q)
			u2d_pkg::ST_IDLE: begin
				load = !qstat.empty;
			end
			u2d_pkg::ST_SHIFT: begin
				shift_en = 1'b1;
			end
			u2d_pkg::ST_EMIT: begin
				emit_adv = !show || out_free;
				emit_out = show && out_free;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	assign qpop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= u2d_pkg::ST_IDLE;
			valid_q   <= 1'b0;
			started_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (emit_out) begin
				valid_q <= 1'b1;
			end else if (!stall) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				started_q <= 1'b0;
			end else if (emit_out) begin
				started_q <= 1'b1;
			end
			if (load) begin
				cnt_q <= CNT_W'(DATA_W);
			end else if (shift_en) begin
				cnt_q <= last_dig ? CNT_W'(NDIG) : cnt_q - CNT_W'(1);
			end else if (emit_adv) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= qdata;
			bcd_q <= '0;
		end else if (shift_en) begin
			bin_q <= {bin_q[DATA_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[DATA_W-1]};
		end else if (emit_adv) begin
			bcd_q <= {bcd_q[BCD_W-u2d_pkg::DIGIT_W-1:0], {u2d_pkg::DIGIT_W{1'b0}}};
		end
		if (emit_out) begin
			char_q <= u2d_pkg::ASCII_ZERO + {2'b00, top_nib};
			last_q <= last_dig;
		end
	end

	assign valid      = valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

endmodule

>>> hw/rtl/unsigned_to_decimal_ascii.sv
// the first shown digit passes the queue, the idle load, the shift-add-3 steps and its digit slot
// each value takes W = min(VALUE_WIDTH, 32) shift-add-3 steps, then D = decimal digit slots
// (10 at 32 bits), a shown digit waiting on digit_stall; the converter loads only when idle
// a two-entry queue takes new values while a conversion runs
// reset: asynchronous, clears the queue, converter state and output valid
module unsigned_to_decimal_ascii #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       value_valid,
	output logic                       value_stall,
	input  logic [31:0]                value,
	output logic                       digit_valid,
	input  logic                       digit_stall,
	output logic [u2d_pkg::CHAR_W-1:0] digit_char,
	output logic                       last_digit
);

	localparam int unsigned EFF_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

	u2d_pkg::queue_stat_t qstat;
	logic [EFF_W-1:0]     qdata;
	logic                 qpop;

	assign value_stall = qstat.full;

	u2d_queue #(
		.DATA_W(EFF_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (value_valid),
		.wdata (value[EFF_W-1:0]),
		.pop   (qpop),
		.rdata (qdata),
		.stat  (qstat)
	);

	u2d_back #(
		.DATA_W(EFF_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.qdata     (qdata),
		.qpop      (qpop),
		.valid     (digit_valid),
		.stall     (digit_stall),
		.digit_char(digit_char),
		.last_digit(last_digit)
	);

endmodule

>>> verif/digit_sb_pkg.sv
`timescale 1ns / 100ps

package digit_sb_pkg;

	typedef struct packed {
		logic [u2d_pkg::CHAR_W-1:0] ch;
		logic                       last;
	} digit_beat_t;

	class digit_scoreboard #(int unsigned VALUE_WIDTH = 32);

		digit_beat_t pending_digits[$];
		int unsigned errors;
		int unsigned values_seen;
		int unsigned digits_checked;
		int unsigned widest;

		function new();
			errors         = 0;
			values_seen    = 0;
			digits_checked = 0;
			widest         = 0;
		endfunction

		function int unsigned pending();
			return pending_digits.size();
		endfunction

		task report_mismatch(input string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		// decimal digits of the masked value, most significant first
		function void note_value(input logic [31:0] v);
			logic [63:0]       x;
			logic [63:0]       mask;
			logic [3:0]        dec[$];
			digit_beat_t       beat;
			mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
			x = {32'd0, v} & mask;
			do begin
				dec.push_front(4'(x % 64'd10));
				x = x / 64'd10;
			end while (x != 0 && dec.size() < 10);
			for (int k = 0; k < dec.size(); k++) begin
				beat.ch   = u2d_pkg::ASCII_ZERO + u2d_pkg::CHAR_W'(dec[k]);
				beat.last = (k == dec.size() - 1);
				pending_digits.push_back(beat);
			end
			if (dec.size() > widest)
				widest = dec.size();
			values_seen++;
		endfunction

		task check_digit(input logic [u2d_pkg::CHAR_W-1:0] ch, input logic last);
			digit_beat_t want;
			digits_checked++;
			if (pending_digits.size() == 0) begin
				report_mismatch($sformatf("digit beat 0x%02h last=%b with none pending",
					ch, last));
			end else begin
				want = pending_digits.pop_front();
				if (ch !== want.ch)
					report_mismatch($sformatf("digit_char 0x%02h, wanted 0x%02h", ch, want.ch));
				if (last !== want.last)
					report_mismatch($sformatf("last_digit %b, wanted %b", last, want.last));
			end
		endtask

	endclass

endpackage

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int unsigned VALUE_WIDTH  = 32;
	localparam int unsigned N_RANDOM     = 360;
	localparam int unsigned IDLE_LIMIT   = 5000;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned TAIL_CYCLES  = 40;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       value_valid = 1'b0;
	logic                       value_stall;
	logic [31:0]                value       = '0;
	logic                       digit_valid;
	logic                       digit_stall = 1'b0;
	logic [u2d_pkg::CHAR_W-1:0] digit_char;
	logic                       last_digit;

	bit                no_idle   = 1'b0;
	bit                long_hold = 1'b0;
	int unsigned       idle_cycles = 0;
	int unsigned       n_directed  = 0;

	digit_sb_pkg::digit_scoreboard #(VALUE_WIDTH) sb = new();

	unsigned_to_decimal_ascii #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.value_valid(value_valid),
		.value_stall(value_stall),
		.value      (value),
		.digit_valid(digit_valid),
		.digit_stall(digit_stall),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (value_valid && !value_stall)
			sb.note_value(value);
		if (digit_valid && !digit_stall)
			sb.check_digit(digit_char, last_digit);
	end

	always @(posedge clk) begin
		if ((value_valid && !value_stall) || (digit_valid && !digit_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d digits pending",
				idle_cycles, sb.pending());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// digit side: per beat a random hold-off, or one long one on request
	initial begin
		int unsigned n;
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				n = LONG_HOLD;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 13);
			end
			if (n > 0) begin
				digit_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			digit_stall <= 1'b0;
			do @(posedge clk); while (!(digit_valid === 1'b1));
		end
	end

	task automatic send_value(input logic [31:0] v, input int unsigned gap);
		if (gap > 0) begin
			value_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		value_valid <= 1'b1;
		value       <= v;
		do @(posedge clk); while (value_stall !== 1'b0);
	endtask

	function automatic logic [63:0] pow10(input int unsigned k);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < k; i++)
			p = p * 64'd10;
		return p;
	endfunction

	function automatic logic [31:0] rand_value();
		int unsigned kind;
		int unsigned k;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] p;
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			k  = $urandom_range(1, 10);
			lo = (k == 1) ? 64'd0 : pow10(k - 1);
			hi = pow10(k) - 64'd1;
			if (hi > 64'hFFFF_FFFF)
				hi = 64'hFFFF_FFFF;
			return $urandom_range(32'(hi), 32'(lo));
		end else if (kind <= 7) begin
			return $urandom;
		end else if (kind == 8) begin
			// just around a power of ten
			p = pow10($urandom_range(1, 9));
			return 32'(p + 64'($urandom_range(0, 4)) - 64'd2);
		end else begin
			return $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31))
				: (32'hFFFF_FFFF >> $urandom_range(0, 31));
		end
	endfunction

	function automatic int unsigned draw_gap();
		return no_idle ? 0 : $urandom_range(0, 13);
	endfunction

	initial begin
		logic [31:0] directed[] = '{
			32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd909,
			32'd65535, 32'd99999, 32'd1000000, 32'd123456789,
			32'd999999999, 32'd1000000000, 32'd1000000001,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd4000000000, 32'd0
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_value(directed[i], draw_gap());
		n_directed = directed.size();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 60) begin
				value_valid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0) @(posedge clk);
			end
			if (i == 120)
				long_hold = 1'b1;
			if (i == 200)
				no_idle = 1'b1;
			if (i == 260)
				no_idle = 1'b0;
			// back-to-back burst while the digit side holds off
			if (i >= 120 && i < 135)
				send_value(rand_value(), 0);
			else
				send_value(rand_value(), draw_gap());
		end
		value_valid <= 1'b0;
		@(posedge clk);

		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d digits never arrived", sb.pending()));

		$display("run: %0d values (%0d directed, %0d random), %0d digit beats checked",
			sb.values_seen, n_directed, N_RANDOM, sb.digits_checked);
		$display("widest number %0d digits, with one long output hold-off and one drain",
			sb.widest);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/u2d_pkg.sv
hw/rtl/u2d_queue.sv
hw/rtl/u2d_back.sv
hw/rtl/unsigned_to_decimal_ascii.sv
verif/digit_sb_pkg.sv
verif/tb.sv
